// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk edge, quiet while reset is asserted.
`define ILS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("indexed_list_store check failed");

// Check on every rising clk edge, reset included.
`define ILS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("indexed_list_store reset check failed");

`endif

// ===== hw/rtl/ils_pkg.sv =====
package ils_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned POS_W     = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_GET    = 2'd2,
    KIND_SET    = 2'd3
  } ils_kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ils_status_t;

  // Broadcast controls from the top level to every cell
  typedef struct packed {
    logic ins_en;
    logic rem_en;
    logic set_en;
    logic rd_en;
  } ils_ctl_t;

endpackage

// ===== hw/rtl/indexed_list_store.sv =====
// Indexed list store: an ordered list of up to DEPTH signed 32-bit words.
// Input channel (in_valid/in_ready): in_kind selects insert, remove, get or
// set at list position in_position; in_value_in is the word to insert or set.
// Result channel (out_valid/out_ready): out_value_out is the removed or read
// word (zero otherwise), out_status is done, position out of range or list
// full, out_count_after is the word count after the operation.
// The list lives in a row of DEPTH cells; insert and remove shift every cell
// behind the position by one in the transfer cycle itself. The read value is
// gathered through a registered OR tree of log2(DEPTH) levels: the leaves
// capture the cell words at the input transfer, the tree merges them toward
// the root and the root is loaded into the output register. One item is in
// flight at a time, until its result moves into the output register.
// A result waiting in the output register does not block the next input
// transfer; that item holds in the tree until the output register frees.
// Reset empties the list (count zero) and drops any result in flight; the
// stored words themselves are not cleared.
module indexed_list_store
  import ils_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [POS_W-1:0]  in_position,
  input  logic [DATA_W-1:0] in_value_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_value_out,
  output logic [1:0]        out_status,
  output logic [POS_W-1:0]  out_count_after
);

  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned XW     = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned LVLS   = $clog2(DEPTH);
  localparam int unsigned N_LEAF = 1 << LVLS;
  localparam int unsigned LW     = $clog2(LVLS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [LW-1:0] LAT_CNT  = LW'(LVLS);

  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                busy_r;
  logic [LW-1:0]       lat_r;
  ils_status_t         status_r;
  ils_status_t         status_nxt;
  logic [POS_W-1:0]    cnt_after_r;
  logic [XW-1:0]       cnt_after_x;
  logic                out_valid_r;
  logic [DATA_W-1:0]   value_r;
  logic [POS_W-1:0]    count_out_r;
  ils_status_t         status_out_r;

  ils_kind_t           kind;
  logic [XW-1:0]       pos_x;
  logic [XW-1:0]       cnt_x;
  logic                accept;
  logic                op_ok;
  logic                done;
  logic                load_out;
  ils_ctl_t            ctl;

  logic [DEPTH-1:0][DATA_W-1:0]  cell_data;
  logic [N_LEAF-1:0][DATA_W-1:0] leaves;
  logic [DATA_W-1:0]             tree_root;

  assign kind   = ils_kind_t'(in_kind);
  assign pos_x  = XW'(in_position);
  assign cnt_x  = XW'(count_r);
  assign accept = in_valid && in_ready;

  // Check the position against the count, then the free space for insert
  always_comb begin
    status_nxt = ST_DONE;
    case (kind)
      KIND_INSERT: begin
        if (pos_x > cnt_x) begin
          status_nxt = ST_RANGE;
        end else if (count_r == FULL_CNT) begin
          status_nxt = ST_FULL;
        end
      end
      KIND_REMOVE, KIND_GET, KIND_SET: begin
        if (pos_x >= cnt_x) begin
          status_nxt = ST_RANGE;
        end
      end
      default: status_nxt = ST_RANGE;
    endcase
  end

  assign op_ok = (status_nxt == ST_DONE);

  // Drive the cell row for this transfer
  always_comb begin
    ctl.ins_en = accept && op_ok && (kind == KIND_INSERT);
    ctl.rem_en = accept && op_ok && (kind == KIND_REMOVE);
    ctl.set_en = accept && op_ok && (kind == KIND_SET);
    ctl.rd_en  = accept && op_ok && ((kind == KIND_REMOVE) || (kind == KIND_GET));
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.rem_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign cnt_after_x = XW'(count_nxt);

  // Row of list cells, each fed by its neighbors
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;

      if (gi == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_data[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_data[gi+1];
      end

      ils_cell #(
        .XW    (XW),
        .INDEX (gi)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .pos        (pos_x),
        .wr_data    (in_value_in),
        .left_data  (left_w),
        .right_data (right_w),
        .data       (cell_data[gi]),
        .leaf       (leaves[gi])
      );
    end

    // Pad the tree up to a power of two
    for (gi = DEPTH; gi < N_LEAF; gi++) begin : g_pad
      assign leaves[gi] = '0;
    end
  endgenerate

  ils_read_tree #(
    .N_LEAF (N_LEAF)
  ) u_tree (
    .clk     (clk),
    .leaf_en (accept),
    .node_en (busy_r && (lat_r != '0)),
    .leaf_in (leaves),
    .root    (tree_root)
  );

  assign done     = busy_r && (lat_r == '0);
  assign load_out = done && (!out_valid_r || out_ready);

  // Track the item in flight and the list count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b0;
      lat_r   <= '0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        busy_r <= 1'b1;
        lat_r  <= LAT_CNT;
      end else if (load_out) begin
        busy_r <= 1'b0;
      end else if (busy_r && (lat_r != '0)) begin
        lat_r <= lat_r - LW'(1);
      end
    end
  end

  // Hold status and count of the item in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      cnt_after_r <= cnt_after_x[POS_W-1:0];
    end
  end

  // Output register, freed by the result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value_r      <= tree_root;
      status_out_r <= status_r;
      count_out_r  <= cnt_after_r;
    end
  end

  assign in_ready        = !busy_r;
  assign out_valid       = out_valid_r;
  assign out_value_out   = value_r;
  assign out_status      = status_out_r;
  assign out_count_after = count_out_r;

endmodule

// ===== hw/rtl/ils_cell.sv =====
module ils_cell
  import ils_pkg::*;
#(
  parameter int unsigned XW    = 7,
  parameter int unsigned INDEX = 0
) (
  input  logic              clk,
  input  ils_ctl_t          ctl,
  input  logic [XW-1:0]     pos,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] leaf
);

  localparam logic [XW-1:0] MY_IDX = XW'(INDEX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              hit;
  logic              behind;

  assign hit    = (pos == MY_IDX);
  assign behind = (MY_IDX > pos);

  // Pick the new word: shift back on insert, forward on remove, or overwrite
  always_comb begin
    data_nxt = data_r;
    if (ctl.ins_en) begin
      if (behind) begin
        data_nxt = left_data;
      end else if (hit) begin
        data_nxt = wr_data;
      end
    end else if (ctl.rem_en) begin
      if (behind || hit) begin
        data_nxt = right_data;
      end
    end else if (ctl.set_en && hit) begin
      data_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

  // Present the old word to the read tree only when this cell is addressed
  assign leaf = (ctl.rd_en && hit) ? data_r : '0;

endmodule

// ===== hw/rtl/ils_read_tree.sv =====
module ils_read_tree
  import ils_pkg::*;
#(
  parameter int unsigned N_LEAF = 64
) (
  input  logic                          clk,
  input  logic                          leaf_en,
  input  logic                          node_en,
  input  logic [N_LEAF-1:0][DATA_W-1:0] leaf_in,
  output logic [DATA_W-1:0]             root
);

  // Heap layout: node 1 is the root, leaves sit at N_LEAF .. 2*N_LEAF-1
  logic [DATA_W-1:0] node_r [1:2*N_LEAF-1];

  genvar gi;

  // Capture the masked cell words
  generate
    for (gi = 0; gi < N_LEAF; gi++) begin : g_leaf
      always_ff @(posedge clk) begin
        if (leaf_en) begin
          node_r[N_LEAF+gi] <= leaf_in[gi];
        end
      end
    end
  endgenerate

  // Merge one level per enabled cycle toward the root
  generate
    for (gi = 1; gi < N_LEAF; gi++) begin : g_node
      always_ff @(posedge clk) begin
        if (node_en) begin
          node_r[gi] <= node_r[2*gi] | node_r[2*gi+1];
        end
      end
    end
  endgenerate

  assign root = node_r[1];

endmodule

// ===== hw/rtl/ils_checker.sv =====
`include "assert_macros.svh"

module ils_checker
  import ils_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_value_out,
  input logic [1:0]        out_status,
  input logic [POS_W-1:0]  out_count_after
);

  localparam logic [POS_W-1:0] FULL_CNT = POS_W'(DEPTH);

  // Stalled result holds its payload
  `ILS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_value_out) && $stable(out_status) && $stable(out_count_after))

  // Failed operations return a zero word
  `ILS_ASSERT(a_err_zero, out_valid && (out_status != ST_DONE) |-> out_value_out == '0)

  // A full report only comes with a full count
  `ILS_ASSERT(a_full_cnt, out_valid && (out_status == ST_FULL) |-> out_count_after == FULL_CNT)

  // Reset drops any pending result
  `ILS_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid)

endmodule

bind indexed_list_store ils_checker #(.DEPTH(DEPTH)) u_ils_checker (.*);

// ===== tb/tb.sv =====
module tb;
  import ils_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int IDX_W        = $clog2(LIST_DEPTH);
  localparam int RANDOM_ITEMS = 1200;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic [1:0]        status;
    logic [POS_W-1:0]  count;
  } list_result_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_CHURN} phase_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [KIND_W-1:0] in_kind;
  logic [POS_W-1:0]  in_position;
  logic [DATA_W-1:0] in_value_in;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] out_value_out;
  logic [1:0]        out_status;
  logic [POS_W-1:0]  out_count_after;

  // Predicted list contents and count
  logic [DATA_W-1:0] list_words [LIST_DEPTH];
  int                words_held;
  int                peak_held;

  list_result_t      result_queue [$];
  bit                steady;
  int                err_count;
  int                cycle_count;
  int                recv_hold;
  int                kind_seen [4];
  int                range_seen;
  int                full_seen;
  int                results_seen;

  indexed_list_store dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_position     (in_position),
    .in_value_in     (in_value_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value_out   (out_value_out),
    .out_status      (out_status),
    .out_count_after (out_count_after)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime, result_queue.size());
      $display("FAIL");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none while steady
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Apply one operation to the predicted list and return its result
  function automatic list_result_t apply_list_op(ils_kind_t kind, logic [POS_W-1:0] pos,
                                                 logic [DATA_W-1:0] val);
    list_result_t     r;
    logic [IDX_W-1:0] idx;
    r.value  = '0;
    r.status = ST_DONE;
    idx      = pos[IDX_W-1:0];
    if (kind == KIND_INSERT) begin
      if (pos > words_held) begin
        r.status = ST_RANGE;
      end else if (words_held >= LIST_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (int i = words_held; i > pos; i--) begin
          list_words[IDX_W'(i)] = list_words[IDX_W'(i-1)];
        end
        list_words[idx] = val;
        words_held++;
      end
    end else if (pos >= words_held) begin
      r.status = ST_RANGE;
    end else begin
      case (kind)
        KIND_REMOVE: begin
          r.value = list_words[idx];
          for (int i = pos; i + 1 < words_held; i++) begin
            list_words[IDX_W'(i)] = list_words[IDX_W'(i+1)];
          end
          words_held--;
        end
        KIND_GET: r.value = list_words[idx];
        default:  list_words[idx] = val;
      endcase
    end
    r.count = words_held[POS_W-1:0];
    if (words_held > peak_held) peak_held = words_held;
    return r;
  endfunction

  // Present one operation, hold it until the transfer, then sometimes idle a while
  task automatic send_op(ils_kind_t kind, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
    int gap;
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_position <= pos;
    in_value_in <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    result_queue.push_back(apply_list_op(kind, pos, val));
    kind_seen[kind]++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Check each result transfer and draw the receiver's stalls
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_status == ST_RANGE) range_seen++;
      if (out_status == ST_FULL) full_seen++;
      if (result_queue.size() == 0) begin
        $display("%0t: unexpected result value %h status %0d count %0d", $realtime,
                 out_value_out, out_status, out_count_after);
        err_count++;
      end else begin
        want = result_queue.pop_front();
        if (out_value_out !== want.value) begin
          $display("%0t: value_out expected %h actual %h", $realtime, want.value,
                   out_value_out);
          err_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.status, out_status);
          err_count++;
        end
        if (out_count_after !== want.count) begin
          $display("%0t: count_after expected %0d actual %0d", $realtime, want.count,
                   out_count_after);
          err_count++;
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_hold > 0) begin
      out_ready <= 1'b0;
      recv_hold--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_hold = pick_gap();
    end
  end

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal positions for the current count, now and then any position up to the depth
  function automatic logic [POS_W-1:0] pick_position(ils_kind_t kind);
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, LIST_DEPTH));
    if (kind == KIND_INSERT) return POS_W'($urandom_range(0, words_held));
    if (words_held == 0) return '0;
    return POS_W'($urandom_range(0, words_held - 1));
  endfunction

  function automatic ils_kind_t pick_kind(phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL:  return (r < 70) ? KIND_INSERT : (r < 80) ? KIND_REMOVE :
                       (r < 90) ? KIND_GET : KIND_SET;
      PH_DRAIN: return (r < 70) ? KIND_REMOVE : (r < 80) ? KIND_INSERT :
                       (r < 90) ? KIND_GET : KIND_SET;
      default:  return ils_kind_t'(r % 4);
    endcase
  endfunction

  // Everything but insert at the front fails on an empty list
  task automatic test_empty_list();
    send_op(KIND_REMOVE, 7'd0, 32'h0);
    send_op(KIND_GET, 7'd0, 32'hFFFF_FFFF);
    send_op(KIND_SET, 7'd0, 32'h5);
    send_op(KIND_INSERT, 7'd1, 32'h1);
    send_op(KIND_INSERT, 7'd64, 32'h2);
  endtask

  // Extreme words at front and back, overwrite, and out-of-range positions
  task automatic test_extreme_words();
    send_op(KIND_INSERT, 7'd0, 32'h7FFF_FFFF);
    send_op(KIND_INSERT, 7'd0, 32'h8000_0000);
    send_op(KIND_INSERT, 7'd2, 32'hFFFF_FFFF);
    send_op(KIND_GET, 7'd0, 32'h0);
    send_op(KIND_GET, 7'd2, 32'h0);
    send_op(KIND_SET, 7'd1, 32'h0);
    send_op(KIND_GET, 7'd1, 32'hAAAA_5555);
    send_op(KIND_GET, 7'd3, 32'h0);
    send_op(KIND_SET, 7'd64, 32'h1);
    send_op(KIND_INSERT, 7'd4, 32'h1);
  endtask

  // Insert in the middle, then remove middle, back and front until empty
  task automatic test_shift_order();
    send_op(KIND_INSERT, 7'd1, 32'h1234_5678);
    send_op(KIND_REMOVE, 7'd1, 32'h0);
    send_op(KIND_REMOVE, 7'd2, 32'h0);
    send_op(KIND_REMOVE, 7'd0, 32'h0);
    send_op(KIND_REMOVE, 7'd0, 32'h0);
    send_op(KIND_REMOVE, 7'd0, 32'h0);
  endtask

  // Random phases weighted toward filling the list, draining it, or churning it
  task automatic test_random_phases();
    int        sent;
    int        len;
    phase_t    ph;
    ils_kind_t kind;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      ph     = phase_t'($urandom_range(0, 2));
      len    = $urandom_range(40, 160);
      steady = ($urandom_range(0, 4) == 0);
      repeat (len) begin
        kind = pick_kind(ph);
        send_op(kind, pick_position(kind), pick_word());
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_kind     = KIND_INSERT;
    in_position = '0;
    in_value_in = '0;
    out_ready   = 1'b0;
    steady      = 1'b0;
    err_count   = 0;
    cycle_count = 0;
    recv_hold   = 0;
    words_held  = 0;
    peak_held   = 0;
    range_seen  = 0;
    full_seen   = 0;
    results_seen = 0;
    kind_seen   = '{default: 0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_extreme_words();
    test_shift_order();
    test_random_phases();

    // Drop valid and let the pipeline empty
    in_valid <= 1'b0;
    while (result_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d results: insert %0d, remove %0d, get %0d, set %0d",
             results_seen, kind_seen[KIND_INSERT], kind_seen[KIND_REMOVE],
             kind_seen[KIND_GET], kind_seen[KIND_SET]);
    $display("Bad positions %0d, full-list inserts %0d, peak count %0d, mismatches %0d",
             range_seen, full_seen, peak_held, err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
